// File: rtl/tts_pkg.sv
// Shared types and constants for the tiled texture swizzle block.
package tts_pkg;

	localparam int unsigned ADDR_W      = 20;
	localparam int unsigned PADDR_W     = 3;
	localparam int unsigned PDATA_W     = 32;
	localparam int unsigned LOG2_W      = 4;
	localparam int unsigned TILE_LOG2   = 3;
	localparam int unsigned TILE_SHIFT  = 6;
	localparam logic [LOG2_W-1:0] MIN_SIDE_LOG2 = 4'd3;
	localparam logic [LOG2_W-1:0] RESET_SIDE_LOG2 = 4'd3;

	typedef enum logic {
		REG_WIDTH_LOG2  = 1'b0,
		REG_HEIGHT_LOG2 = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} pixel_t;

	typedef struct packed {
		logic [ADDR_W-1:0] word_address;
		logic [31:0]       texel_word;
		logic              last_texel;
	} texel_t;

endpackage

// File: rtl/tiled_texture_swizzle.sv
// Top level: raster RGBA8 pixels to 8x8-tiled Z-order texel words.
//
//  channel  direction  handshake              payload
//  pix      in         pix_valid/pix_ready    tts_pkg::pixel_t
//  texel    out        texel_valid/texel_ready tts_pkg::texel_t
//  apb      in         psel/penable/pready    width_log2 @0x0, height_log2 @0x4
//
// One pixel per cycle while the output is not stalled; each texel is registered before it appears.
// Address and packing are computed from the column/row counters at accept and held
// in the result register; a skid register takes one more pixel while the output stalls,
// so pix_ready depends only on registered state.
// Reset clears counters and buffers and sets both size registers to 8 pixels.
module tiled_texture_swizzle #(
	parameter int unsigned MAX_SIDE_LOG2 = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pix_valid,
	output logic                          pix_ready,
	input  tts_pkg::pixel_t               pix,
	output logic                          texel_valid,
	input  logic                          texel_ready,
	output tts_pkg::texel_t               texel,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tts_pkg::PADDR_W-1:0]   paddr,
	input  logic [tts_pkg::PDATA_W-1:0]   pwdata,
	output logic [tts_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam int unsigned CNT_W  = MAX_SIDE_LOG2;
	localparam int unsigned CALC_W = (2 * MAX_SIDE_LOG2 > tts_pkg::ADDR_W) ?
		2 * MAX_SIDE_LOG2 : tts_pkg::ADDR_W;
	localparam logic [tts_pkg::LOG2_W-1:0] MAX_LOG2 = tts_pkg::LOG2_W'(MAX_SIDE_LOG2);
	localparam int unsigned TILE_BITS = 2 * tts_pkg::TILE_LOG2;

	logic [tts_pkg::LOG2_W-1:0] width_log2_q;
	logic [tts_pkg::LOG2_W-1:0] height_log2_q;
	logic [CNT_W-1:0]           col_q;
	logic [CNT_W-1:0]           row_q;

	logic [tts_pkg::LOG2_W-1:0] wl;
	logic [tts_pkg::LOG2_W-1:0] hl;
	logic [CNT_W-1:0]           wmask;
	logic [CNT_W-1:0]           hmask;
	logic [CNT_W-1:0]           col;
	logic [CNT_W-1:0]           row;
	logic [CNT_W-1:0]           dy;
	logic [TILE_BITS-1:0]       zord;
	logic [4:0]                 row_shift;
	logic [CALC_W-1:0]          addr_full;
	logic                       col_end;
	logic                       row_end;
	tts_pkg::texel_t            result;

	tts_pkg::texel_t            main_q;
	logic                       main_vld_q;
	tts_pkg::texel_t            skid_q;
	logic                       skid_vld_q;

	logic                       pix_fire;
	logic                       cfg_wr;

	assign pready    = 1'b1;
	assign cfg_wr    = psel & penable & pwrite & pready;
	assign pix_ready = ~skid_vld_q;
	assign pix_fire  = pix_valid & pix_ready;

	always_comb begin
		unique case (tts_pkg::reg_idx_t'(paddr[2]))
			tts_pkg::REG_WIDTH_LOG2:  prdata = tts_pkg::PDATA_W'(width_log2_q);
			tts_pkg::REG_HEIGHT_LOG2: prdata = tts_pkg::PDATA_W'(height_log2_q);
			default:                  prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_log2_q  <= tts_pkg::RESET_SIDE_LOG2;
			height_log2_q <= tts_pkg::RESET_SIDE_LOG2;
		end else if (cfg_wr) begin
			unique case (tts_pkg::reg_idx_t'(paddr[2]))
				tts_pkg::REG_WIDTH_LOG2:  width_log2_q  <= pwdata[tts_pkg::LOG2_W-1:0];
				tts_pkg::REG_HEIGHT_LOG2: height_log2_q <= pwdata[tts_pkg::LOG2_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_log2_q < tts_pkg::MIN_SIDE_LOG2)
			wl = tts_pkg::MIN_SIDE_LOG2;
		else if (width_log2_q > MAX_LOG2)
			wl = MAX_LOG2;
		else
			wl = width_log2_q;
		if (height_log2_q < tts_pkg::MIN_SIDE_LOG2)
			hl = tts_pkg::MIN_SIDE_LOG2;
		else if (height_log2_q > MAX_LOG2)
			hl = MAX_LOG2;
		else
			hl = height_log2_q;
		for (int i = 0; i < CNT_W; i++) begin
			wmask[i] = (i < int'(wl));
			hmask[i] = (i < int'(hl));
		end
	end

	assign col       = col_q & wmask;
	assign row       = row_q & hmask;
	assign dy        = ~row & hmask;
	assign col_end   = (col == wmask);
	assign row_end   = (row == hmask);
	assign zord      = {dy[2], col[2], dy[1], col[1], dy[0], col[0]};
	assign row_shift = {1'b0, wl} + 5'(tts_pkg::TILE_LOG2);
	assign addr_full = (CALC_W'(dy >> tts_pkg::TILE_LOG2) << row_shift)
		| (CALC_W'(col >> tts_pkg::TILE_LOG2) << tts_pkg::TILE_SHIFT)
		| CALC_W'(zord);

	assign result.word_address = addr_full[tts_pkg::ADDR_W-1:0];
	assign result.texel_word   = {pix.red, pix.green, pix.blue, pix.alpha};
	assign result.last_texel   = col_end & row_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (pix_fire) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row + 1'b1;
			end else begin
				col_q <= col + 1'b1;
				row_q <= row;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!main_vld_q || texel_ready) begin
			if (skid_vld_q) begin
				main_vld_q <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				main_vld_q <= pix_fire;
			end
		end else if (pix_fire) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!main_vld_q || texel_ready) begin
			if (skid_vld_q)
				main_q <= skid_q;
			else if (pix_fire)
				main_q <= result;
		end else if (pix_fire) begin
			skid_q <= result;
		end
	end

	assign texel_valid = main_vld_q;
	assign texel       = main_q;

	a_skid_implies_main: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> main_vld_q)
		else $error("skid entry held while result register empty");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_ready |-> (texel_valid && !$past(texel_ready && texel_valid && !skid_vld_q)))
		else $error("pixel channel stalled without a pending texel");

	a_fire_fills_output: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_fire && !main_vld_q) |=> texel_valid)
		else $error("accepted pixel did not reach the result register");

	a_last_wraps_counters: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_fire && col_end && row_end) |=> (col_q == '0 && row_q == '0))
		else $error("counters did not wrap after the final pixel");

endmodule

// File: tb/tts_swizzle_check.sv
`timescale 1ns / 1ps
// Watches the pixel, texel and register ports and checks every texel against its prediction.
module tts_swizzle_check #(
	parameter int unsigned MAX_SIDE_LOG2 = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        pix_valid,
	input  logic                        pix_ready,
	input  tts_pkg::pixel_t             pix,
	input  logic                        texel_valid,
	input  logic                        texel_ready,
	input  tts_pkg::texel_t             texel,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [tts_pkg::PADDR_W-1:0] paddr,
	input  logic [tts_pkg::PDATA_W-1:0] pwdata,
	output int                          errors,
	output int                          pending
);

	logic [tts_pkg::LOG2_W-1:0] width_log2_q;
	logic [tts_pkg::LOG2_W-1:0] height_log2_q;
	logic [MAX_SIDE_LOG2-1:0]   column_q;
	logic [MAX_SIDE_LOG2-1:0]   row_q;
	tts_pkg::texel_t            texel_fifo[$];

	function automatic int unsigned side_log2(logic [tts_pkg::LOG2_W-1:0] v);
		if (v < tts_pkg::MIN_SIDE_LOG2)
			return 32'(tts_pkg::MIN_SIDE_LOG2);
		if (v > MAX_SIDE_LOG2)
			return MAX_SIDE_LOG2;
		return 32'(v);
	endfunction

	function automatic tts_pkg::texel_t predict_texel(tts_pkg::pixel_t p);
		int unsigned     wl;
		int unsigned     hl;
		int unsigned     wmask;
		int unsigned     hmask;
		int unsigned     col;
		int unsigned     row;
		int unsigned     dy;
		logic [2:0]      tx;
		logic [2:0]      ty;
		tts_pkg::texel_t t;
		wl = side_log2(width_log2_q);
		hl = side_log2(height_log2_q);
		wmask = (1 << wl) - 1;
		hmask = (1 << hl) - 1;
		col = column_q & wmask;
		row = row_q & hmask;
		dy = hmask - row;
		tx = col[2:0];
		ty = dy[2:0];
		t.word_address = tts_pkg::ADDR_W'(((dy >> tts_pkg::TILE_LOG2)
			<< (wl + tts_pkg::TILE_LOG2))
			+ ((col >> tts_pkg::TILE_LOG2) << tts_pkg::TILE_SHIFT)
			+ {ty[2], tx[2], ty[1], tx[1], ty[0], tx[0]});
		t.texel_word = {p.red, p.green, p.blue, p.alpha};
		t.last_texel = (col == wmask) && (row == hmask);
		if (col == wmask) begin
			column_q = '0;
			row_q = (row == hmask) ? '0 : MAX_SIDE_LOG2'(row + 1);
		end else begin
			column_q = MAX_SIDE_LOG2'(col + 1);
			row_q = MAX_SIDE_LOG2'(row);
		end
		return t;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		tts_pkg::texel_t want;
		int              fails;
		if (!arst_n) begin
			width_log2_q = tts_pkg::RESET_SIDE_LOG2;
			height_log2_q = tts_pkg::RESET_SIDE_LOG2;
			column_q = '0;
			row_q = '0;
			texel_fifo.delete();
			errors <= 0;
			pending <= 0;
		end else begin
			fails = 0;
			if (texel_valid && texel_ready) begin
				if (texel_fifo.size() == 0) begin
					$display("%0t: unexpected texel: expected none actual %h", $time, texel);
					fails++;
				end else begin
					want = texel_fifo.pop_front();
					if (texel.word_address !== want.word_address) begin
						$display("%0t: word_address expected %h actual %h",
							$time, want.word_address, texel.word_address);
						fails++;
					end
					if (texel.texel_word !== want.texel_word) begin
						$display("%0t: texel_word expected %h actual %h",
							$time, want.texel_word, texel.texel_word);
						fails++;
					end
					if (texel.last_texel !== want.last_texel) begin
						$display("%0t: last_texel expected %b actual %b",
							$time, want.last_texel, texel.last_texel);
						fails++;
					end
				end
			end
			if (pix_valid && pix_ready)
				texel_fifo.push_back(predict_texel(pix));
			if (psel && penable && pwrite && pready) begin
				if (paddr == {tts_pkg::REG_WIDTH_LOG2, 2'b00})
					width_log2_q = pwdata[tts_pkg::LOG2_W-1:0];
				else if (paddr == {tts_pkg::REG_HEIGHT_LOG2, 2'b00})
					height_log2_q = pwdata[tts_pkg::LOG2_W-1:0];
			end
			errors <= errors + fails;
			pending <= texel_fifo.size();
		end
	end

endmodule

// File: tb/tb_tiled_texture_swizzle.sv
`timescale 1ns / 1ps
// Drives pixels and size settings into the tiled texture swizzle block and reports the verdict.
module tb_tiled_texture_swizzle;

	localparam int unsigned SIDE_LOG2_MAX = 10;
	localparam int unsigned RANDOM_PIXELS = 550;

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        pix_valid;
	logic                        pix_ready;
	tts_pkg::pixel_t             pix;
	logic                        texel_valid;
	logic                        texel_ready;
	tts_pkg::texel_t             texel;
	logic                        psel;
	logic                        penable;
	logic                        pwrite;
	logic [tts_pkg::PADDR_W-1:0] paddr;
	logic [tts_pkg::PDATA_W-1:0] pwdata;
	logic [tts_pkg::PDATA_W-1:0] prdata;
	logic                        pready;
	int                          errors;
	int                          pending;
	int                          src_gap_max = 4;
	int                          sink_gap_max = 4;
	int                          sink_hold = 0;
	int                          pixels_sent = 0;

	always #2 clk = ~clk;

	tiled_texture_swizzle #(
		.MAX_SIDE_LOG2(SIDE_LOG2_MAX)
	) dut (.*);

	tts_swizzle_check #(
		.MAX_SIDE_LOG2(SIDE_LOG2_MAX)
	) swizzle_check (.*);

	task automatic write_reg(input tts_pkg::reg_idx_t idx,
			input logic [tts_pkg::LOG2_W-1:0] value);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = $urandom();
		pwdata[tts_pkg::LOG2_W-1:0] = value;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic send_pixel(input tts_pkg::pixel_t p);
		int gap;
		gap = $urandom_range(0, src_gap_max);
		if (gap > 0) begin
			pix_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix_valid = 1'b1;
		pix = p;
		do @(posedge clk); while (!pix_ready);
		@(negedge clk);
	endtask

	task automatic drain();
		pix_valid = 1'b0;
		wait (pending == 0);
		@(negedge clk);
	endtask

	task automatic run_texture(input logic [tts_pkg::LOG2_W-1:0] wl,
			input logic [tts_pkg::LOG2_W-1:0] hl, input int unsigned count);
		write_reg(tts_pkg::REG_WIDTH_LOG2, wl);
		write_reg(tts_pkg::REG_HEIGHT_LOG2, hl);
		repeat (count) send_pixel(tts_pkg::pixel_t'($urandom()));
		drain();
		pixels_sent += count;
	endtask

	initial begin : sink
		int gap;
		texel_ready = 1'b0;
		@(negedge clk);
		forever begin
			if (sink_hold > 0) begin
				texel_ready = 1'b0;
				repeat (sink_hold) @(negedge clk);
				sink_hold = 0;
			end
			gap = $urandom_range(0, sink_gap_max);
			if (gap > 0) begin
				texel_ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			texel_ready = 1'b1;
			do @(posedge clk); while (!texel_valid);
			@(negedge clk);
		end
	end

	initial begin : stimulus
		int unsigned pick;
		int unsigned wl;
		int unsigned hl;
		arst_n = 1'b0;
		pix_valid = 1'b0;
		pix = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_pixel(32'h0000_0000);
		send_pixel(32'hFFFF_FFFF);
		send_pixel(32'hFF00_0000);
		send_pixel(32'h00FF_0000);
		send_pixel(32'h0000_FF00);
		send_pixel(32'h0000_00FF);
		send_pixel(32'hA5A5_5A5A);
		send_pixel(32'h5A5A_A5A5);
		drain();
		// clamp below the floor and above the ceiling, counters left mid-texture
		run_texture(4'd0, 4'd15, 4);
		run_texture(4'd15, 4'd2, 4);
		run_texture(4'd10, 4'd10, 4);
		run_texture(4'd3, 4'd3, 4);

		// hold the sink off while the source streams, so the input stalls
		pixels_sent = 0;
		src_gap_max = 0;
		sink_hold = 60;
		run_texture(4'd3, 4'd3, 64);

		while (pixels_sent < RANDOM_PIXELS) begin
			src_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
			sink_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 4;
			pick = $urandom_range(0, 9);
			if (pick < 5) begin
				run_texture(4'd3, 4'd3, 64);
			end else if (pick == 5) begin
				wl = $urandom_range(3, 4);
				hl = 7 - wl;
				run_texture(tts_pkg::LOG2_W'(wl), tts_pkg::LOG2_W'(hl), 128);
			end else if (pick < 8) begin
				run_texture(tts_pkg::LOG2_W'($urandom_range(3, 10)),
					tts_pkg::LOG2_W'($urandom_range(3, 10)), $urandom_range(1, 24));
			end else begin
				run_texture(tts_pkg::LOG2_W'($urandom_range(0, 15)),
					tts_pkg::LOG2_W'($urandom_range(0, 15)), $urandom_range(1, 16));
			end
		end

		drain();
		repeat (8) @(negedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
